### hw/rtl/bftrqv_pkg.sv
// shared types, codes and defaults for the reply quorum voter
package bftrqv_pkg;

  // default sizing
  localparam int MAX_REPLICAS_DEF    = 16;
  localparam int MAX_REPLY_BYTES_DEF = 1024;
  localparam int DIGEST_WORDS_DEF    = 4;

  // field widths
  localparam int SENDER_W  = 4;
  localparam int REQ_W     = 32;
  localparam int LEN_W     = 11;
  localparam int WORD_W    = 64;
  localparam int COUNT_W   = 5;
  localparam int FAULTY_W  = 3;
  localparam int REPLICA_W = 5;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [FAULTY_W-1:0]  FAULTY_RST  = 3'd1;
  localparam logic [REPLICA_W-1:0] REPLICA_RST = 5'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAULTY_LIMIT  = 1'b0,
    REG_REPLICA_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_DUP      = 3'd1,
    ST_QUORUM   = 3'd2,
    ST_CLEARED  = 3'd3,
    ST_OVERSIZE = 3'd4
  } status_t;

  typedef struct packed {
    logic                req_type;
    logic [SENDER_W-1:0] sender_id;
    logic [REQ_W-1:0]    request_id;
    logic [LEN_W-1:0]    reply_length;
    logic [WORD_W-1:0]   digest_word0;
    logic [WORD_W-1:0]   digest_word1;
    logic [WORD_W-1:0]   digest_word2;
    logic [WORD_W-1:0]   digest_word3;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [SENDER_W-1:0] winner_id;
    logic [LEN_W-1:0]    winner_length;
    logic [COUNT_W-1:0]  match_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic decide;
    logic scan;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;
    logic scan_done;
  } dp_sts_t;

endpackage

### hw/rtl/bftrqv_dp.sv
// datapath: slot memory, valid bits, slot scan and result register
module bftrqv_dp
  import bftrqv_pkg::*;
#(
  parameter int MAX_REPLICAS    = MAX_REPLICAS_DEF,
  parameter int MAX_REPLY_BYTES = MAX_REPLY_BYTES_DEF,
  parameter int DIGEST_WORDS    = DIGEST_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  in_item_t             in_data,
  input  logic [FAULTY_W-1:0]  faulty_limit,
  input  logic [REPLICA_W-1:0] replica_count,
  output out_item_t            out_data
);

  localparam int SW    = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  localparam int CW    = $clog2(MAX_REPLICAS + 1);
  localparam int DIG_W = DIGEST_WORDS * WORD_W;
  localparam int ROW_W = REQ_W + LEN_W + DIG_W;

  // captured transaction
  logic                type_r;
  logic [SENDER_W-1:0] sender_r;
  logic [REQ_W-1:0]    rid_r;
  logic [LEN_W-1:0]    len_r;
  logic [DIG_W-1:0]    dig_r;
  logic [4*WORD_W-1:0] dig_full;

  // slot storage
  logic [ROW_W-1:0]        mem [MAX_REPLICAS];
  logic [ROW_W-1:0]        rd_r;
  logic [SW-1:0]           rd_addr;
  logic [MAX_REPLICAS-1:0] valid_r;
  logic [MAX_REPLICAS-1:0] valid_nxt;

  // scan state
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [SW-1:0]    pend_idx_r, pend_idx_nxt;
  logic             have_win_r, have_win_nxt;
  logic [SW-1:0]    win_r, win_nxt;
  logic [DIG_W-1:0] wdig_r, wdig_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             scan_path_r, scan_path_nxt;
  status_t          res_status_r, res_status_nxt;
  out_item_t        out_r;

  logic [SW-1:0]    sa;
  logic             sender_ok;
  logic             dup;
  logic             oversize;
  logic             early;
  status_t          early_status;
  logic [CW-1:0]    scan_lim;
  logic             issue;
  logic [REQ_W-1:0] rd_req;
  logic [LEN_W-1:0] rd_len;
  logic [DIG_W-1:0] rd_dig;
  logic             hit;
  logic             quorum;
  out_item_t        res;

  assign dig_full = {in_data.digest_word3, in_data.digest_word2,
                     in_data.digest_word1, in_data.digest_word0};

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r   <= in_data.req_type;
      sender_r <= in_data.sender_id;
      rid_r    <= in_data.request_id;
      len_r    <= in_data.reply_length;
      dig_r    <= dig_full[DIG_W-1:0];
    end
  end

  // sender slot checks
  assign sa        = SW'(sender_r);
  assign sender_ok = {{(32-SENDER_W){1'b0}}, sender_r} < 32'(MAX_REPLICAS);
  assign rd_req    = rd_r[DIG_W+LEN_W +: REQ_W];
  assign rd_len    = rd_r[DIG_W +: LEN_W];
  assign rd_dig    = rd_r[DIG_W-1:0];
  assign dup       = sender_ok && valid_r[sa] && (rd_req == rid_r);
  assign oversize  = {{(32-LEN_W){1'b0}}, len_r} > 32'(MAX_REPLY_BYTES);
  assign early     = type_r || !sender_ok || dup || oversize;

  always_comb begin
    if (type_r) begin
      early_status = ST_CLEARED;
    end else if (!sender_ok) begin
      early_status = ST_STORED;
    end else if (dup) begin
      early_status = ST_DUP;
    end else begin
      early_status = ST_OVERSIZE;
    end
  end

  // scan bound and issue
  assign scan_lim = ({{(32-REPLICA_W){1'b0}}, replica_count} < 32'(MAX_REPLICAS)) ?
                    CW'(replica_count) : CW'(MAX_REPLICAS);
  assign issue    = cmd.scan && (idx_r < scan_lim);
  assign rd_addr  = issue ? idx_r[SW-1:0] : sa;
  assign hit      = pend_vld_r && valid_r[pend_idx_r] && (rd_req == rid_r) &&
                    (rd_len == len_r);

  // slot memory, registered read
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
    if (cmd.decide && !early) begin
      mem[sa] <= {rid_r, len_r, dig_r};
    end
  end

  // quorum check and result
  assign quorum = {{(32-CW){1'b0}}, cnt_r} >=
                  ({{(32-FAULTY_W){1'b0}}, faulty_limit} + 32'd1);

  always_comb begin
    res = '{status: ST_STORED, winner_id: '0, winner_length: '0, match_count: '0};
    if (!scan_path_r) begin
      res.status = res_status_r;
    end else if (have_win_r) begin
      res.status        = quorum ? ST_QUORUM : ST_STORED;
      res.winner_id     = SENDER_W'(win_r);
      res.winner_length = len_r;
      res.match_count   = COUNT_W'(cnt_r);
    end
  end

  // next state of valid bits and scan
  always_comb begin
    valid_nxt      = valid_r;
    idx_nxt        = idx_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    have_win_nxt   = have_win_r;
    win_nxt        = win_r;
    wdig_nxt       = wdig_r;
    cnt_nxt        = cnt_r;
    scan_path_nxt  = scan_path_r;
    res_status_nxt = res_status_r;
    if (cmd.decide) begin
      if (type_r) begin
        valid_nxt = '0;
      end else if (sender_ok && !dup) begin
        valid_nxt[sa] = !oversize;
      end
      idx_nxt        = '0;
      pend_vld_nxt   = 1'b0;
      have_win_nxt   = 1'b0;
      cnt_nxt        = '0;
      scan_path_nxt  = !early;
      res_status_nxt = early_status;
    end
    if (cmd.scan) begin
      pend_vld_nxt = issue;
      pend_idx_nxt = idx_r[SW-1:0];
      if (issue) begin
        idx_nxt = idx_r + CW'(1);
      end
      if (hit) begin
        if (!have_win_r) begin
          have_win_nxt = 1'b1;
          win_nxt      = pend_idx_r;
          wdig_nxt     = rd_dig;
          cnt_nxt      = CW'(1);
        end else if (rd_dig == wdig_r) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
    end
    if (cmd.emit && scan_path_r && have_win_r && quorum) begin
      valid_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      idx_r       <= '0;
      pend_vld_r  <= 1'b0;
      have_win_r  <= 1'b0;
      cnt_r       <= '0;
      scan_path_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      idx_r       <= idx_nxt;
      pend_vld_r  <= pend_vld_nxt;
      have_win_r  <= have_win_nxt;
      cnt_r       <= cnt_nxt;
      scan_path_r <= scan_path_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    win_r        <= win_nxt;
    wdig_r       <= wdig_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.emit) begin
      out_r <= res;
    end
  end

  assign sts.early     = early;
  assign sts.scan_done = !issue && !pend_vld_r;
  assign out_data      = out_r;

endmodule

### hw/rtl/bftrqv_ctrl.sv
// controller: transaction sequencing and output valid
module bftrqv_ctrl
  import bftrqv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SCAN   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.early ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // a result is never loaded over one still held
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result loaded while output held");

  // accepted transaction moves to slot lookup
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_LOOKUP))
    else $error("accept did not start lookup");

  // finished scan hands over to emit
  a_scan_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.scan_done) |=> (state_r == S_EMIT))
    else $error("scan end not followed by emit");

  // output valid rises only from an emit
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("output valid without emit");
`endif

endmodule

### hw/rtl/bft_reply_quorum_voter.sv
// reply quorum voter top level: config registers, controller and datapath
// sequence: accept, slot lookup, decide, a scan of N = min(replica_count, MAX_REPLICAS)
// slots, then emit into the result register; emit waits while a held result is stalled
// clear, duplicate, oversize and out-of-range senders skip the scan and go from decide to emit
// one transaction in flight at a time; the next is taken while the result waits
// synchronous active-low reset empties all slots and restores the registers
module bft_reply_quorum_voter
  import bftrqv_pkg::*;
#(
  parameter int MAX_REPLICAS    = MAX_REPLICAS_DEF,
  parameter int MAX_REPLY_BYTES = MAX_REPLY_BYTES_DEF,
  parameter int DIGEST_WORDS    = DIGEST_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [FAULTY_W-1:0]  faulty_limit_r;
  logic [REPLICA_W-1:0] replica_count_r;
  dp_cmd_t              cmd;
  dp_sts_t              sts;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      faulty_limit_r  <= FAULTY_RST;
      replica_count_r <= REPLICA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FAULTY_LIMIT:  faulty_limit_r  <= cfg_wdata[FAULTY_W-1:0];
        REG_REPLICA_COUNT: replica_count_r <= cfg_wdata[REPLICA_W-1:0];
        default: begin
          faulty_limit_r <= faulty_limit_r;
        end
      endcase
    end
  end

  bftrqv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bftrqv_dp #(
    .MAX_REPLICAS    (MAX_REPLICAS),
    .MAX_REPLY_BYTES (MAX_REPLY_BYTES),
    .DIGEST_WORDS    (DIGEST_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data       (in_data),
    .faulty_limit  (faulty_limit_r),
    .replica_count (replica_count_r),
    .out_data      (out_data)
  );

endmodule

### tb/tb_bft_reply_quorum_voter.sv
`timescale 1ns / 1ps
// self-checking testbench for the reply quorum voter, with a built-in slot vote predictor
module tb_bft_reply_quorum_voter;
  import bftrqv_pkg::*;

  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 170;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 30;

  // clock, reset and block ports
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bft_reply_quorum_voter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register settings per random phase, extremes included
  int faulty_plan [PHASES]  = '{0, 5, 7, 2, 3, 1, 6, 4, 0};
  int replica_plan [PHASES] = '{4, 16, 31, 0, 8, 4, 16, 12, 20};

  // predictor copy of the slots and registers
  logic                slot_live [MAX_REPLICAS_DEF];
  logic [REQ_W-1:0]    slot_rid  [MAX_REPLICAS_DEF];
  logic [LEN_W-1:0]    slot_len  [MAX_REPLICAS_DEF];
  logic [4*WORD_W-1:0] slot_dig  [MAX_REPLICAS_DEF];
  logic [FAULTY_W-1:0]  vote_faulty;
  logic [REPLICA_W-1:0] vote_span;

  // transactions waiting to be sent, and verdicts waiting to come back
  in_item_t  arrivals [$];
  out_item_t verdicts_due [$];

  int   queued      = 0;
  int   checked     = 0;
  int   errors      = 0;
  int   cycle_count = 0;
  int   seen_status [8] = '{default: 0};
  int   in_gap      = 0;
  int   out_gap     = 0;
  bit   in_quiet    = 1'b0;
  bit   out_quiet   = 1'b0;
  logic in_taken    = 1'b0;
  logic out_taken   = 1'b0;
  logic [REQ_W-1:0] last_rid = '0;

  function automatic void drop_slots();
    for (int i = 0; i < MAX_REPLICAS_DEF; i++) slot_live[i] = 1'b0;
  endfunction

  // apply one transaction to the slot copy and return the verdict it must give
  function automatic out_item_t tally_reply(in_item_t t);
    out_item_t r;
    int span;
    int win;
    int cnt;
    bit found;
    logic [4*WORD_W-1:0] dig;
    r     = '0;
    found = 1'b0;
    win   = 0;
    cnt   = 0;
    dig   = {t.digest_word3, t.digest_word2, t.digest_word1, t.digest_word0};
    if (t.req_type) begin
      drop_slots();
      r.status = ST_CLEARED;
      return r;
    end
    // same request from the same replica is ignored, even when oversize
    if (slot_live[t.sender_id]) begin
      if (slot_rid[t.sender_id] == t.request_id) begin
        r.status = ST_DUP;
        return r;
      end
      slot_live[t.sender_id] = 1'b0;
    end
    if (t.reply_length > MAX_REPLY_BYTES_DEF) begin
      r.status = ST_OVERSIZE;
      return r;
    end
    slot_live[t.sender_id] = 1'b1;
    slot_rid[t.sender_id]  = t.request_id;
    slot_len[t.sender_id]  = t.reply_length;
    slot_dig[t.sender_id]  = dig;
    // lowest matching slot wins, then count digest agreement with it
    span = (vote_span < MAX_REPLICAS_DEF) ? vote_span : MAX_REPLICAS_DEF;
    for (int i = 0; i < span; i++) begin
      if (slot_live[i] && slot_rid[i] == t.request_id && slot_len[i] == t.reply_length) begin
        if (!found) begin
          found = 1'b1;
          win   = i;
          cnt   = 1;
        end else if (slot_dig[i] == slot_dig[win]) begin
          cnt++;
        end
      end
    end
    if (!found) return r;
    r.winner_id     = win[SENDER_W-1:0];
    r.winner_length = slot_len[win];
    r.match_count   = cnt[COUNT_W-1:0];
    if (cnt >= vote_faulty + 1) begin
      r.status = ST_QUORUM;
      drop_slots();
    end
    return r;
  endfunction

  function automatic logic [4*WORD_W-1:0] rand_digest();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic in_item_t make_item(bit kind, int s, logic [REQ_W-1:0] rid, int len,
                                         logic [4*WORD_W-1:0] dig);
    in_item_t t;
    t.req_type     = kind;
    t.sender_id    = SENDER_W'(s);
    t.request_id   = rid;
    t.reply_length = LEN_W'(len);
    t.digest_word0 = dig[63:0];
    t.digest_word1 = dig[127:64];
    t.digest_word2 = dig[191:128];
    t.digest_word3 = dig[255:192];
    return t;
  endfunction

  function automatic in_item_t noise_item();
    return make_item($urandom_range(0, 15) == 0, $urandom_range(0, 15), $urandom,
                     $urandom_range(0, 2047), rand_digest());
  endfunction

  function automatic void queue_item(in_item_t t);
    arrivals.push_back(t);
    queued++;
  endfunction

  function automatic int pick_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  // one voting round: many replicas answer the same request, some faulty
  task automatic queue_round();
    logic [REQ_W-1:0]    rid;
    int                  len;
    logic [4*WORD_W-1:0] dig;
    logic [4*WORD_W-1:0] bad;
    int span;
    int k;
    int s;
    int prev;
    int roll;
    span = (vote_span == 0 || vote_span > MAX_REPLICAS_DEF) ? MAX_REPLICAS_DEF : vote_span;
    rid  = ($urandom_range(0, 7) == 0) ? last_rid : $urandom;
    if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 1) ? 1024 : 0;
    else len = $urandom_range(0, 1024);
    dig  = rand_digest();
    k    = $urandom_range(1, span + 2);
    prev = 0;
    for (int j = 0; j < k; j++) begin
      s    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, span - 1);
      roll = $urandom_range(0, 99);
      bad  = dig;
      bad[$urandom_range(0, 255)] ^= 1'b1;
      if (roll < 70)      queue_item(make_item(1'b0, s, rid, len, dig));
      else if (roll < 80) queue_item(make_item(1'b0, s, rid, len, bad));
      else if (roll < 85) queue_item(make_item(1'b0, s, rid, len ^ 1, dig));
      else if (roll < 90) queue_item(make_item(1'b0, s, rid, $urandom_range(1025, 2047), dig));
      else if (roll < 96) queue_item(make_item(1'b0, prev, rid, len, dig));
      else if (roll < 98) queue_item(noise_item());
      else queue_item(make_item(1'b1, s, $urandom, $urandom_range(0, 2047), rand_digest()));
      prev = s;
    end
    last_rid = rid;
  endtask

  // register write over the config channel, predictor follows on the handshake
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FAULTY_LIMIT) vote_faulty = val[FAULTY_W-1:0];
    else vote_span = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold until every queued transaction is sent and every verdict is back
  task automatic wait_idle();
    while (arrivals.size() != 0 || in_valid || verdicts_due.size() != 0) @(posedge clk);
  endtask

  // input driver: holds a stalled transaction, otherwise waits its gap and sends the next
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_valid) in_gap = pick_wait(in_quiet);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (arrivals.size() > 0) begin
        in_data  <= arrivals.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure: a fresh stall stretch after each accepted result
  always @(negedge clk) begin
    if (out_taken) out_gap = pick_wait(out_quiet);
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on accepted input, check each accepted result in order
  always @(posedge clk) begin
    out_item_t want;
    cycle_count++;
    in_taken  <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) verdicts_due.push_back(tally_reply(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result transaction, status %0d", out_data.status);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        checked++;
        seen_status[want.status]++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.winner_id !== want.winner_id) begin
          $error("winner_id: expected %0d, got %0d", want.winner_id, out_data.winner_id);
          errors++;
        end
        if (out_data.winner_length !== want.winner_length) begin
          $error("winner_length: expected %0d, got %0d", want.winner_length,
                 out_data.winner_length);
          errors++;
        end
        if (out_data.match_count !== want.match_count) begin
          $error("match_count: expected %0d, got %0d", want.match_count, out_data.match_count);
          errors++;
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    logic [4*WORD_W-1:0] da;
    logic [4*WORD_W-1:0] db;
    logic [CFG_DATA_W-1:0] fval;
    int mark;
    vote_faulty = FAULTY_RST;
    vote_span   = REPLICA_RST;
    drop_slots();
    da = rand_digest();
    db = da;
    db[255] = ~db[255];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corner cases at reset settings
    queue_item(make_item(1'b1, 15, 32'hFFFF_FFFF, 2047, '1));   // clear ignores fields
    queue_item(make_item(1'b0, 0, 32'h0, 0, '0));
    queue_item(make_item(1'b0, 0, 32'h0, 1024, '1));            // duplicate
    queue_item(make_item(1'b0, 0, 32'h0, 2047, '1));            // duplicate beats oversize
    queue_item(make_item(1'b0, 1, 32'h0, 0, '0));               // quorum
    queue_item(make_item(1'b0, 2, 32'hFFFF_FFFF, 1025, '1));    // oversize
    queue_item(make_item(1'b0, 2, 32'hFFFF_FFFF, 1024, '1));
    queue_item(make_item(1'b0, 2, 32'd5, 7, da));               // stale slot replaced
    queue_item(make_item(1'b0, 3, 32'd5, 7, db));               // digest disagrees
    queue_item(make_item(1'b0, 15, 32'd5, 7, da));              // sender outside scan
    queue_item(make_item(1'b0, 3, 32'd6, 2047, da));            // stale then oversize
    queue_item(make_item(1'b0, 1, 32'd5, 8, da));               // length disagrees
    queue_item(make_item(1'b0, 0, 32'd5, 7, da));               // quorum from lower slot
    queue_item(make_item(1'b0, 3, 32'd9, 100, db));
    queue_item(make_item(1'b0, 1, 32'd9, 100, da));
    queue_item(make_item(1'b0, 2, 32'd9, 100, da));
    queue_item(make_item(1'b1, 0, 32'h0, 0, '0));
    wait_idle();

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      in_quiet  = (p % 3 == 2);
      out_quiet = (p % 4 == 1);
      fval      = CFG_DATA_W'(faulty_plan[p]);
      fval[4:3] = 2'($urandom_range(0, 3));
      write_reg(REG_FAULTY_LIMIT, fval);
      write_reg(REG_REPLICA_COUNT, CFG_DATA_W'(replica_plan[p]));
      mark = queued;
      while (queued - mark < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) queue_round();
        else queue_item(noise_item());
      end
      wait_idle();
    end
    repeat (SETTLE) @(posedge clk);

    $display("checked %0d result transactions under %0d register settings",
             checked, PHASES + 1);
    $display("stored %0d, duplicate %0d, quorum %0d, cleared %0d, oversize %0d",
             seen_status[ST_STORED], seen_status[ST_DUP], seen_status[ST_QUORUM],
             seen_status[ST_CLEARED], seen_status[ST_OVERSIZE]);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/bftrqv_pkg.sv
hw/rtl/bftrqv_dp.sv
hw/rtl/bftrqv_ctrl.sv
hw/rtl/bft_reply_quorum_voter.sv
tb/tb_bft_reply_quorum_voter.sv
